// ===== rtl/core/mvrd_pkg.sv =====
package mvrd_pkg;

   localparam int COLS_CFG_BITS = 11;
   localparam int ROWS_CFG_BITS = 13;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 13;
   localparam int ROW_NUM_BITS  = 12;
   localparam int ACC_BITS      = 48;
   localparam int QUEUE_DEPTH   = 4;

   localparam logic [CSR_IDX_BITS-1:0] CSR_NUM_COLS = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_NUM_ROWS = 2'd1;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_MATRIX = 1'b1;

   typedef struct packed {
      logic                    op;
      logic                    row_end;
      logic                    last_row;
      logic [ROW_NUM_BITS-1:0] row_number;
   } mvrd_tag_type;

   typedef struct packed {
      logic s2_valid;
      logic s2_row_end;
   } mvrd_back_status_type;

endpackage

// ===== rtl/core/mvrd_if.sv =====
interface mvrd_req_if #(parameter int ELEM_BITS = 16) ();
   logic                        valid;
   logic                        ready;
   logic                        opcode;
   logic signed [ELEM_BITS-1:0] value;

   modport source (output valid, opcode, value, input ready);
   modport sink (input valid, opcode, value, output ready);
endinterface

interface mvrd_rsp_if import mvrd_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [ACC_BITS-1:0] row_sum;
   logic [ROW_NUM_BITS-1:0]    row_number;
   logic                       last_row;

   modport source (output valid, row_sum, row_number, last_row, input ready);
   modport sink (input valid, row_sum, row_number, last_row, output ready);
endinterface

interface mvrd_csr_if import mvrd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_BITS-1:0]  index;
   logic [CSR_DATA_BITS-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/mvrd_front.sv =====
module mvrd_front import mvrd_pkg::*; #(
   parameter int MAX_COLS  = 1024,
   parameter int MAX_ROWS  = 4096,
   parameter int ELEM_BITS = 16,
   localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   mvrd_req_if.sink                    req,
   mvrd_csr_if.sink                    csr,
   input  logic                        push_ready,
   output logic                        push_valid,
   output mvrd_tag_type                push_tag,
   output logic [AW-1:0]               push_addr,
   output logic signed [ELEM_BITS-1:0] push_value
);

   localparam int CW = $clog2(MAX_COLS + 1);
   localparam int RW = $clog2(MAX_ROWS + 1);

   logic [COLS_CFG_BITS-1:0] num_cols_ff;
   logic [ROWS_CFG_BITS-1:0] num_rows_ff;
   logic [AW-1:0]            ld_idx_ff, ld_idx_in;
   logic [AW-1:0]            col_ff, col_in;
   logic [ROW_NUM_BITS-1:0]  row_ff, row_in;

   logic [CW-1:0] cols_eff;
   logic [RW-1:0] rows_eff;
   logic [AW-1:0] ld_cur, col_cur;
   logic          ld_wrap, col_wrap, row_last, is_matrix, accept;

   always_comb begin
      if (num_cols_ff == '0) begin
         cols_eff = CW'(1);
      end else if (32'(num_cols_ff) > 32'(MAX_COLS)) begin
         cols_eff = CW'(MAX_COLS);
      end else begin
         cols_eff = CW'(num_cols_ff);
      end
      if (num_rows_ff == '0) begin
         rows_eff = RW'(1);
      end else if (32'(num_rows_ff) > 32'(MAX_ROWS)) begin
         rows_eff = RW'(MAX_ROWS);
      end else begin
         rows_eff = RW'(num_rows_ff);
      end
   end

   assign ld_cur   = (32'(ld_idx_ff) < 32'(cols_eff)) ? ld_idx_ff : '0;
   assign col_cur  = (32'(col_ff) < 32'(cols_eff)) ? col_ff : '0;
   assign ld_wrap  = (32'(ld_cur) + 32'd1) >= 32'(cols_eff);
   assign col_wrap = (32'(col_cur) + 32'd1) >= 32'(cols_eff);
   assign row_last = (32'(row_ff) + 32'd1) >= 32'(rows_eff);

   assign is_matrix = (req.opcode == OP_MATRIX);
   assign accept    = req.valid && push_ready;

   assign req.ready  = push_ready;
   assign csr.ready  = 1'b1;
   assign push_valid = req.valid;
   assign push_value = req.value;
   assign push_addr  = is_matrix ? col_cur : ld_cur;

   always_comb begin
      push_tag.op         = req.opcode;
      push_tag.row_end    = is_matrix && col_wrap;
      push_tag.last_row   = is_matrix && col_wrap && row_last;
      push_tag.row_number = row_ff;
   end

   always_comb begin
      ld_idx_in = ld_idx_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (accept) begin
         if (is_matrix) begin
            col_in = col_wrap ? '0 : col_cur + AW'(1);
            if (col_wrap) begin
               row_in = row_last ? '0 : row_ff + ROW_NUM_BITS'(1);
            end
         end else begin
            ld_idx_in = ld_wrap ? '0 : ld_cur + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_cols_ff <= COLS_CFG_BITS'(1);
         num_rows_ff <= ROWS_CFG_BITS'(1);
         ld_idx_ff   <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
      end else begin
         ld_idx_ff <= ld_idx_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         if (csr.valid) begin
            case (csr.index)
               CSR_NUM_COLS: num_cols_ff <= csr.data[COLS_CFG_BITS-1:0];
               CSR_NUM_ROWS: num_rows_ff <= csr.data[ROWS_CFG_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== rtl/core/mvrd_queue.sv =====
module mvrd_queue import mvrd_pkg::*; #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]    head_ff, tail_ff;
   logic [PW:0]      count_ff;
   logic             push, pop;

   assign push_ready = (count_ff != (PW+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[head_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[tail_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            tail_ff <= tail_ff + PW'(1);
         end
         if (pop) begin
            head_ff <= head_ff + PW'(1);
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + (PW+1)'(1);
            2'b01:   count_ff <= count_ff - (PW+1)'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ===== rtl/core/mvrd_back.sv =====
module mvrd_back import mvrd_pkg::*; #(
   parameter int MAX_COLS  = 1024,
   parameter int ELEM_BITS = 16,
   localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        pop_valid,
   output logic                        pop_ready,
   input  mvrd_tag_type                pop_tag,
   input  logic [AW-1:0]               pop_addr,
   input  logic signed [ELEM_BITS-1:0] pop_value,
   mvrd_rsp_if.source                  rsp,
   output mvrd_back_status_type        status
);

   logic signed [ELEM_BITS-1:0]   vec_mem [MAX_COLS];
   logic signed [ELEM_BITS-1:0]   x_ff, s1_value_ff;
   logic                          s1_valid_ff;
   mvrd_tag_type                  s1_tag_ff, s2_tag_ff;
   logic                          s2_valid_ff;
   logic signed [2*ELEM_BITS-1:0] prod_ff;
   logic signed [ACC_BITS-1:0]    acc_ff, acc_in, sum;
   logic signed [ACC_BITS-1:0]    rsp_sum_ff;
   logic [ROW_NUM_BITS-1:0]       rsp_row_ff;
   logic                          rsp_last_ff, rsp_valid_ff, rsp_valid_in;
   logic                          adv, take, emit;

   assign adv       = !rsp_valid_ff || rsp.ready;
   assign take      = pop_valid && adv;
   assign pop_ready = adv;
   assign sum       = acc_ff + ACC_BITS'(prod_ff);
   assign emit      = adv && s2_valid_ff && s2_tag_ff.row_end;

   always_comb begin
      acc_in = acc_ff;
      if (adv && s2_valid_ff) begin
         acc_in = s2_tag_ff.row_end ? '0 : sum;
      end
      rsp_valid_in = emit ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (take) begin
         if (pop_tag.op == OP_LOAD) begin
            vec_mem[pop_addr] <= pop_value;
         end
         x_ff <= vec_mem[pop_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_value_ff <= pop_value;
         s1_tag_ff   <= pop_tag;
         prod_ff     <= s1_value_ff * x_ff;
         s2_tag_ff   <= s1_tag_ff;
      end
      if (emit) begin
         rsp_sum_ff  <= sum;
         rsp_row_ff  <= s2_tag_ff.row_number;
         rsp_last_ff <= s2_tag_ff.last_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            s1_valid_ff <= take && (pop_tag.op == OP_MATRIX);
            s2_valid_ff <= s1_valid_ff;
         end
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.row_sum    = rsp_sum_ff;
   assign rsp.row_number = rsp_row_ff;
   assign rsp.last_row   = rsp_last_ff;

   assign status.s2_valid   = s2_valid_ff;
   assign status.s2_row_end = s2_tag_ff.row_end;

endmodule

// ===== rtl/core/matrix_vector_row_dot.sv =====
// Integer matrix-vector multiply, one row sum per matrix row. Load the vector with opcode 0
// words, one element each, from entry 0 up, wrapping after num_cols elements; then stream
// the matrix row-major with opcode 1 words. Each row end yields one word with the exact
// 48-bit row sum, its row number and a last-row flag; the row count wraps after the last row
// and a new matrix reuses the stored vector. The block takes one word per cycle, loads and
// matrix elements alike, while the queue has room; once the back end takes a row's last
// element, its row sum passes through the vector store read, the multiplier register and the
// result register. A four-word queue between the front end and the multiply-accumulate
// pipeline lets the input keep flowing while a result waits. The vector store has no reset,
// so a column must be loaded before a matrix element reads it. Write num_cols and num_rows
// only while no matrix words are in flight.
module matrix_vector_row_dot import mvrd_pkg::*; #(
   parameter int MAX_COLS  = 1024,
   parameter int MAX_ROWS  = 4096,
   parameter int ELEM_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   mvrd_req_if.sink   req_chan,
   mvrd_rsp_if.source rsp_chan,
   mvrd_csr_if.sink   csr_chan
);

   localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int TW = $bits(mvrd_tag_type);
   localparam int QW = TW + AW + ELEM_BITS;

   logic                        q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
   mvrd_tag_type                fr_tag, bk_tag;
   logic [AW-1:0]               fr_addr, bk_addr;
   logic signed [ELEM_BITS-1:0] fr_value, bk_value;
   logic [QW-1:0]               q_pop_data;
   mvrd_back_status_type        bk_status;

   mvrd_front #(
      .MAX_COLS  (MAX_COLS),
      .MAX_ROWS  (MAX_ROWS),
      .ELEM_BITS (ELEM_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .csr        (csr_chan),
      .push_ready (q_push_ready),
      .push_valid (q_push_valid),
      .push_tag   (fr_tag),
      .push_addr  (fr_addr),
      .push_value (fr_value)
   );

   mvrd_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_data  ({fr_tag, fr_addr, fr_value}),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_data   (q_pop_data)
   );

   assign bk_tag   = q_pop_data[QW-1 -: TW];
   assign bk_addr  = q_pop_data[ELEM_BITS +: AW];
   assign bk_value = q_pop_data[ELEM_BITS-1:0];

   mvrd_back #(
      .MAX_COLS  (MAX_COLS),
      .ELEM_BITS (ELEM_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (q_pop_valid),
      .pop_ready (q_pop_ready),
      .pop_tag   (bk_tag),
      .pop_addr  (bk_addr),
      .pop_value (bk_value),
      .rsp       (rsp_chan),
      .status    (bk_status)
   );

   a_rsp_from_row_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(bk_status.s2_valid && bk_status.s2_row_end))
      else $error("result word without a finished row");

   a_row_end_on_matrix: assert property (@(posedge clock) disable iff (reset)
      (q_push_valid && q_push_ready && fr_tag.row_end) |-> (fr_tag.op == OP_MATRIX))
      else $error("row end tagged on a vector load");

   a_last_on_row_end: assert property (@(posedge clock) disable iff (reset)
      (q_push_valid && q_push_ready && fr_tag.last_row) |-> fr_tag.row_end)
      else $error("last row flag without a row end");

endmodule
